>>> hw/rtl/graph_adjacency_store_macros.svh
// Assertion helpers for the graph store checker
`ifndef GRAPH_ADJACENCY_STORE_MACROS_SVH
`define GRAPH_ADJACENCY_STORE_MACROS_SVH

// clocked assertion, off while reset is asserted
`define GAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also runs through reset
`define GAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/gas_pkg.sv
package gas_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned KEY_BITS     = 16;
  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned ADDR_W       = 2 * IDX_W;

  typedef enum logic [2:0] {
    REQ_ADD_V   = 3'd0,
    REQ_DEL_V   = 3'd1,
    REQ_SET_E   = 3'd2,
    REQ_DEL_E   = 3'd3,
    REQ_READ_W  = 3'd4,
    REQ_LIST    = 3'd5,
    REQ_CLEAR   = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DISPATCH,
    S_CROSS,
    S_WREAD,
    S_LIST
  } state_e;

  typedef struct packed {
    logic [2:0]             req_type;
    logic [KEY_BITS-1:0]    from_key;
    logic [KEY_BITS-1:0]    to_key;
    logic [WEIGHT_BITS-1:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [WEIGHT_BITS-1:0] weight_out;
    logic [KEY_BITS-1:0]    neighbor_key;
    logic                   neighbor_valid;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic                clr_all;
    logic                we;
    logic                inval;
    logic [IDX_W-1:0]    waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } kt_cmd_t;

endpackage

>>> hw/rtl/gas_ram.sv
module gas_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/gas_key_table.sv
module gas_key_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gas_pkg::kt_cmd_t             cmd_i,
  output logic [gas_pkg::KEY_BITS-1:0] rdata_o,
  output logic                         rvalid_o
);
  import gas_pkg::*;

  logic [KEY_BITS-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid_q;
  logic [KEY_BITS-1:0] rdata_q;
  logic rvalid_q;

  // key storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wdata;
    end
    rdata_q <= mem[cmd_i.raddr];
  end

  // occupancy bits: an empty slot reads with rvalid low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[cmd_i.raddr];
      if (cmd_i.clr_all) begin
        valid_q <= '0;
      end else if (cmd_i.we) begin
        valid_q[cmd_i.waddr] <= 1'b1;
      end else if (cmd_i.inval) begin
        valid_q[cmd_i.waddr] <= 1'b0;
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

>>> hw/rtl/graph_adjacency_store.sv
// Steps: a request first sweeps the slots handed out so far for both keys;
// add/delete vertex then clear the slot's row and column with a row write and
// a column write per swept slot; edge requests use one matrix entry; listing walks the row.
// Throughput: one request at a time, busy is high until its last beat.
// Reset clears the slot count, free list pointers, occupancy bits and the
// no-edge register; the weight matrix and free list storage are not reset.
module graph_adjacency_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  gas_pkg::req_t                   req_i,
  output logic                            res_valid_o,
  output gas_pkg::res_t                   res_o,
  input  logic                            cfg_we_i,
  input  logic [gas_pkg::WEIGHT_BITS-1:0] cfg_wdata_i
);
  import gas_pkg::*;

  state_e st_q, st_d;
  req_t   req_q, req_d;

  logic [CNT_W-1:0] slots_q, slots_d;   // fresh slots handed out so far
  logic [IDX_W-1:0] fhead_q, fhead_d;
  logic [IDX_W-1:0] ftail_q, ftail_d;
  logic [CNT_W-1:0] fcnt_q, fcnt_d;
  logic [WEIGHT_BITS-1:0] nullw_q;

  // sweep counter and one-deep read pipeline
  logic [CNT_W-1:0] scnt_q, scnt_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] paddr_q, paddr_d;

  // search results
  logic             fr_q, fr_d, fc_q, fc_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d;

  // slot whose row and column are cleared; phase picks row or column write
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             phase_q, phase_d;

  // listing holds one neighbor back so the final one can carry last
  logic                pend_q, pend_d;
  logic [KEY_BITS-1:0] pend_key_q, pend_key_d;

  res_t res_q, res_d;
  logic res_vld_q, res_vld_d;

  kt_cmd_t             kt_cmd;
  logic [KEY_BITS-1:0] kt_rdata;
  logic                kt_rvalid;

  logic                   wm_we;
  logic [ADDR_W-1:0]      wm_waddr, wm_raddr;
  logic [WEIGHT_BITS-1:0] wm_wdata, wm_rdata;

  logic             ff_we;
  logic [IDX_W-1:0] ff_rdata;

  logic sweep_more;
  assign sweep_more = scnt_q < slots_q;

  gas_key_table u_keys (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (kt_cmd),
    .rdata_o  (kt_rdata),
    .rvalid_o (kt_rvalid)
  );

  // slot-by-slot weight matrix, row = source slot
  gas_ram #(
    .DEPTH (MAX_VERTICES * MAX_VERTICES),
    .WIDTH (WEIGHT_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (wm_we),
    .waddr_i (wm_waddr),
    .wdata_i (wm_wdata),
    .raddr_i (wm_raddr),
    .rdata_o (wm_rdata)
  );

  // freed-slot queue; head entry is read continuously and is long settled
  // by the time an add needs it
  gas_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (IDX_W)
  ) u_free (
    .clk_i   (clk_i),
    .we_i    (ff_we),
    .waddr_i (ftail_q),
    .wdata_i (r_q),
    .raddr_i (fhead_q),
    .rdata_o (ff_rdata)
  );

  always_comb begin
    st_d       = st_q;
    req_d      = req_q;
    slots_d    = slots_q;
    fhead_d    = fhead_q;
    ftail_d    = ftail_q;
    fcnt_d     = fcnt_q;
    scnt_d     = scnt_q;
    pv_d       = 1'b0;
    paddr_d    = paddr_q;
    fr_d       = fr_q;
    fc_d       = fc_q;
    r_d        = r_q;
    c_d        = c_q;
    slot_d     = slot_q;
    phase_d    = phase_q;
    pend_d     = pend_q;
    pend_key_d = pend_key_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;

    kt_cmd     = '0;
    wm_we      = 1'b0;
    wm_waddr   = {r_q, c_q};
    wm_wdata   = nullw_q;
    wm_raddr   = {r_q, c_q};
    ff_we      = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          fr_d   = 1'b0;
          fc_d   = 1'b0;
          scnt_d = '0;
          st_d   = S_SEARCH;
        end
      end

      // look up both keys in one pass over the slots handed out so far
      S_SEARCH: begin
        if (sweep_more) begin
          kt_cmd.raddr = scnt_q[IDX_W-1:0];
          pv_d         = 1'b1;
          paddr_d      = scnt_q[IDX_W-1:0];
          scnt_d       = scnt_q + CNT_W'(1);
        end else if (!pv_q) begin
          st_d = S_DISPATCH;
        end
        if (pv_q && kt_rvalid) begin
          if (!fr_q && req_q.from_key != '0 && kt_rdata == req_q.from_key) begin
            fr_d = 1'b1;
            r_d  = paddr_q;
          end
          if (!fc_q && req_q.to_key != '0 && kt_rdata == req_q.to_key) begin
            fc_d = 1'b1;
            c_d  = paddr_q;
          end
        end
      end

      S_DISPATCH: begin
        res_d       = '0;
        res_d.last  = 1'b1;
        scnt_d      = '0;
        phase_d     = 1'b0;
        pend_d      = 1'b0;
        st_d        = S_IDLE;
        unique case (req_q.req_type)
          REQ_ADD_V: begin
            if (req_q.from_key == '0 || fr_q) begin
              res_vld_d = 1'b1;
            end else if (fcnt_q != '0) begin
              slot_d  = ff_rdata;
              fhead_d = fhead_q + IDX_W'(1);
              fcnt_d  = fcnt_q - CNT_W'(1);
              st_d    = S_CROSS;
            end else if (slots_q != CNT_W'(MAX_VERTICES)) begin
              slot_d  = slots_q[IDX_W-1:0];
              slots_d = slots_q + CNT_W'(1);
              st_d    = S_CROSS;
            end else begin
              res_d.status = ST_FULL;
              res_vld_d    = 1'b1;
            end
            if (st_d == S_CROSS) begin
              kt_cmd.we    = 1'b1;
              kt_cmd.waddr = slot_d;
              kt_cmd.wdata = req_q.from_key;
            end
          end
          REQ_DEL_V: begin
            if (!fr_q) begin
              res_d.status = ST_NOT_FOUND;
              res_vld_d    = 1'b1;
            end else begin
              slot_d       = r_q;
              kt_cmd.inval = 1'b1;
              kt_cmd.waddr = r_q;
              if (fcnt_q != CNT_W'(MAX_VERTICES)) begin
                ff_we   = 1'b1;
                ftail_d = ftail_q + IDX_W'(1);
                fcnt_d  = fcnt_q + CNT_W'(1);
              end
              st_d = S_CROSS;
            end
          end
          REQ_SET_E, REQ_DEL_E: begin
            if (!fr_q || !fc_q) begin
              res_d.status = ST_NOT_FOUND;
            end else begin
              wm_we    = 1'b1;
              wm_wdata = (req_q.req_type == REQ_SET_E) ? req_q.edge_weight : nullw_q;
            end
            res_vld_d = 1'b1;
          end
          REQ_READ_W: begin
            if (!fr_q || !fc_q) begin
              res_d.status = ST_NOT_FOUND;
              res_vld_d    = 1'b1;
            end else begin
              st_d = S_WREAD;
            end
          end
          REQ_LIST: begin
            if (!fr_q) begin
              res_d.status = ST_NOT_FOUND;
              res_vld_d    = 1'b1;
            end else begin
              st_d = S_LIST;
            end
          end
          REQ_CLEAR: begin
            kt_cmd.clr_all = 1'b1;
            slots_d        = '0;
            fhead_d        = '0;
            ftail_d        = '0;
            fcnt_d         = '0;
            res_vld_d      = 1'b1;
          end
          default: begin
            res_vld_d = 1'b1;
          end
        endcase
      end

      // row write then column write per slot handed out so far
      S_CROSS: begin
        if (sweep_more) begin
          wm_we    = 1'b1;
          wm_waddr = phase_q ? {scnt_q[IDX_W-1:0], slot_q} : {slot_q, scnt_q[IDX_W-1:0]};
          phase_d  = !phase_q;
          if (phase_q) begin
            scnt_d = scnt_q + CNT_W'(1);
          end
        end else begin
          res_d      = '0;
          res_d.last = 1'b1;
          res_vld_d  = 1'b1;
          st_d       = S_IDLE;
        end
      end

      S_WREAD: begin
        res_d            = '0;
        res_d.weight_out = wm_rdata;
        res_d.last       = 1'b1;
        res_vld_d        = 1'b1;
        st_d             = S_IDLE;
      end

      // walk the source row and the key table side by side
      S_LIST: begin
        if (sweep_more) begin
          kt_cmd.raddr = scnt_q[IDX_W-1:0];
          wm_raddr     = {r_q, scnt_q[IDX_W-1:0]};
          pv_d         = 1'b1;
          scnt_d       = scnt_q + CNT_W'(1);
        end else if (!pv_q) begin
          res_d                = '0;
          res_d.neighbor_key   = pend_q ? pend_key_q : '0;
          res_d.neighbor_valid = pend_q;
          res_d.last           = 1'b1;
          res_vld_d            = 1'b1;
          st_d                 = S_IDLE;
        end
        if (pv_q && kt_rvalid && wm_rdata != nullw_q) begin
          if (pend_q) begin
            res_d                = '0;
            res_d.neighbor_key   = pend_key_q;
            res_d.neighbor_valid = 1'b1;
            res_vld_d            = 1'b1;
          end
          pend_d     = 1'b1;
          pend_key_d = kt_rdata;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      slots_q   <= '0;
      fhead_q   <= '0;
      ftail_q   <= '0;
      fcnt_q    <= '0;
      nullw_q   <= '0;
      pv_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      slots_q   <= slots_d;
      fhead_q   <= fhead_d;
      ftail_q   <= ftail_d;
      fcnt_q    <= fcnt_d;
      pv_q      <= pv_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        nullw_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    scnt_q     <= scnt_d;
    paddr_q    <= paddr_d;
    fr_q       <= fr_d;
    fc_q       <= fc_d;
    r_q        <= r_d;
    c_q        <= c_d;
    slot_q     <= slot_d;
    phase_q    <= phase_d;
    pend_q     <= pend_d;
    pend_key_q <= pend_key_d;
    res_q      <= res_d;
  end

  assign busy        = st_q != S_IDLE;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/gas_checker.sv
`include "graph_adjacency_store_macros.svh"

module gas_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input gas_pkg::res_t res_o
);
  import gas_pkg::*;

  // every accepted request makes the block busy in the next cycle
  `GAS_ASSERT(a_start_busy, (start && !busy) |=> busy, "request not taken up")
  // more beats follow a non-final result, so the sequencer is still running
  `GAS_ASSERT(a_more_busy, (res_valid_o && !res_o.last) |-> busy, "idle before last beat")
  // a neighbor beat is always a successful one
  `GAS_ASSERT(a_nb_ok, (res_valid_o && res_o.neighbor_valid) |-> (res_o.status == ST_OK),
              "neighbor beat with error status")
  // busy only rises after an accepted request
  `GAS_ASSERT(a_busy_src, $rose(busy) |-> $past(start), "busy without request")

endmodule

bind graph_adjacency_store gas_checker u_gas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
